/* hw/rtl/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg
// shared types and constants for the tick scheduler task table
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int MAX_TASKS_DEF = 8;
  // most results a single dispatch item may produce
  localparam int RES_CAP       = 8;
  localparam int CNT_W         = $clog2(RES_CAP + 1);

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_DISP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] task_tag;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic [5:0]  slot_sel;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_out;
    logic        run_valid;
    logic [15:0] run_tag;
    logic        last;
  } rsp_t;

  // one table slot as kept in the slot memory
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PROC,
    S_ADD,
    S_DEL,
    S_FIN
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic cap;
    logic rd;
    logic step;
    logic tick_wr;
    logic disp_wr;
    logic add_wr;
    logic add_full;
    logic del_do;
    logic fin;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    func_t func;
    logic  idx_last;
    logic  used_idx;
    logic  pending_nz;
    logic  out_ready;
    logic  hold_valid;
    logic  cap_hit;
  } stat_t;

endpackage

/* hw/rtl/tst_ctrl.sv */
// ----------------------------------------------------------------------------
// tst_ctrl
// sequencer that walks the slot table for each item
// ----------------------------------------------------------------------------
module tst_ctrl
  import tst_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  func_t req_func,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.cap = 1'b1;
          case (req_func)
            FUNC_ADD: state_next = S_ADD;
            FUNC_DEL: state_next = S_DEL;
            default:  state_next = S_READ;
          endcase
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_PROC;
      end
      S_PROC: begin
        if (stat.func == FUNC_TICK || !stat.pending_nz) begin
          cmd.tick_wr = (stat.func == FUNC_TICK);
          if (stat.idx_last) begin
            state_next = S_FIN;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_READ;
          end
        end else if (stat.hold_valid && !stat.out_ready) begin
          // earlier run still waiting for room in the output register
          state_next = S_PROC;
        end else begin
          cmd.disp_wr = 1'b1;
          if (stat.idx_last || stat.cap_hit) begin
            state_next = S_FIN;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_ADD: begin
        if (!stat.used_idx) begin
          cmd.add_wr = 1'b1;
          state_next = S_FIN;
        end else if (stat.idx_last) begin
          cmd.add_full = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DEL: begin
        cmd.del_do = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_ready) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_stall = (state != S_IDLE);

endmodule

/* hw/rtl/tst_dp.sv */
// ----------------------------------------------------------------------------
// tst_dp
// slot memory, occupancy bits, slot walker, result hold and output register
// ----------------------------------------------------------------------------
module tst_dp
  import tst_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output stat_t stat,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  req_t                 req_q;
  logic [SLOT_W-1:0]    idx;
  logic [CNT_W-1:0]     cnt;
  rsp_t                 hold;
  logic                 hold_valid;
  logic [MAX_TASKS-1:0] used;
  entry_t               slot_mem [MAX_TASKS];
  entry_t               rd_data;
  rsp_t                 out_q;
  logic                 out_valid;

  entry_t            ent;
  entry_t            tick_ent;
  entry_t            disp_ent;
  entry_t            add_ent;
  entry_t            wr_ent;
  logic              mem_we;
  logic              out_ready;
  logic              push;
  rsp_t              push_data;
  logic              sel_in_range;
  logic [SLOT_W-1:0] sel_idx;

  // a free slot reads as all zero
  assign ent = used[idx] ? rd_data : '0;

  always_comb begin
    tick_ent = ent;
    if (ent.delay == 16'd0) begin
      if (ent.pending != 8'hFF) begin
        tick_ent.pending = ent.pending + 8'd1;
      end
      if (ent.period != 16'd0) begin
        tick_ent.delay = ent.period;
      end
    end else begin
      tick_ent.delay = ent.delay - 16'd1;
    end
  end

  always_comb begin
    disp_ent         = ent;
    disp_ent.pending = ent.pending - 8'd1;
  end

  assign add_ent = '{tag: req_q.task_tag, delay: req_q.start_delay,
                     period: req_q.repeat_period, pending: 8'd0};

  assign mem_we = (cmd.tick_wr && used[idx]) || cmd.disp_wr || cmd.add_wr;

  always_comb begin
    if (cmd.add_wr) begin
      wr_ent = add_ent;
    end else if (cmd.disp_wr) begin
      wr_ent = disp_ent;
    end else begin
      wr_ent = tick_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx] <= wr_ent;
    end
    if (cmd.rd) begin
      rd_data <= slot_mem[idx];
    end
  end

  assign sel_in_range = ({1'b0, req_q.slot_sel} < 7'(MAX_TASKS));
  assign sel_idx      = req_q.slot_sel[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.add_wr) begin
        used[idx] <= 1'b1;
      end
      if (cmd.disp_wr && ent.period == 16'd0) begin
        used[idx] <= 1'b0;
      end
      if (cmd.del_do && sel_in_range) begin
        used[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      cnt        <= '0;
      hold_valid <= 1'b0;
    end else if (cmd.cap) begin
      idx        <= '0;
      cnt        <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.disp_wr) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.disp_wr || cmd.add_wr || cmd.add_full || cmd.del_do) begin
        hold_valid <= 1'b1;
      end else if (cmd.fin) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.disp_wr) begin
      hold <= '{status: ST_OK, slot_out: 6'(idx), run_valid: 1'b1,
                run_tag: ent.tag, last: 1'b0};
    end else if (cmd.add_wr) begin
      hold <= '{status: ST_OK, slot_out: 6'(idx), run_valid: 1'b0,
                run_tag: 16'd0, last: 1'b0};
    end else if (cmd.add_full) begin
      hold <= '{status: ST_FULL, slot_out: 6'd0, run_valid: 1'b0,
                run_tag: 16'd0, last: 1'b0};
    end else if (cmd.del_do) begin
      hold <= '{status: !sel_in_range ? ST_RANGE : (used[sel_idx] ? ST_OK : ST_EMPTY),
                slot_out: req_q.slot_sel, run_valid: 1'b0, run_tag: 16'd0, last: 1'b0};
    end
  end

  // output register
  assign out_ready = !out_valid || !rsp_stall;
  assign push      = cmd.fin || (cmd.disp_wr && hold_valid);

  always_comb begin
    if (!cmd.fin) begin
      push_data = hold;
    end else if (hold_valid) begin
      push_data      = hold;
      push_data.last = 1'b1;
    end else begin
      push_data = '{status: ST_OK, slot_out: 6'd0, run_valid: 1'b0,
                    run_tag: 16'd0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!rsp_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_q <= push_data;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_q;

  assign stat.func       = req_q.func;
  assign stat.idx_last   = (idx == SLOT_W'(MAX_TASKS - 1));
  assign stat.used_idx   = used[idx];
  assign stat.pending_nz = (ent.pending != 8'd0);
  assign stat.out_ready  = out_ready;
  assign stat.hold_valid = hold_valid;
  assign stat.cap_hit    = (cnt == CNT_W'(RES_CAP - 1));

  a_fin_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> out_ready)
    else $error("final result pushed into a full output register");

  a_run_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.disp_wr && hold_valid) |-> out_ready)
    else $error("held run pushed into a full output register");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold.run_valid) |-> (cnt != '0))
    else $error("held run without a counted result");

  a_used_stable: assert property (@(posedge clk) disable iff (rst)
    !(cmd.add_wr || cmd.disp_wr || cmd.del_do) |=> $stable(used))
    else $error("slot occupancy changed without a command");

endmodule

/* hw/rtl/tick_scheduler_task_table.sv */
// ----------------------------------------------------------------------------
// tick_scheduler_task_table
// time-triggered cooperative task table with tick, add, delete and dispatch
// ----------------------------------------------------------------------------
// The block holds MAX_TASKS task slots and takes one request item at a time:
// tick ages every occupied slot, add places a task in the lowest free slot,
// delete frees one slot and dispatch returns every slot with pending runs in
// slot order (at most eight results, the last one flagged). Slot contents sit
// in a single-port-read memory with a registered read, so tick and dispatch
// visit each slot in a read state and then a process state; a dispatch ends
// early once its eighth run is out. Add walks the slots up to the lowest free
// one, delete goes straight to its selected slot, and every item is held while
// the result side stalls. req_stall is high from acceptance until the final
// result has entered the output register, which then waits on its own.
// ----------------------------------------------------------------------------
module tick_scheduler_task_table
  import tst_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: decides per cycle which slot operation the datapath performs
  tst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: slot memory, occupancy bits, result hold and output register
  tst_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the tick scheduler task table
// ----------------------------------------------------------------------------
// Request items come from a backlog queue that the stimulus process fills.
// A clocked driver offers them with random gaps, and a clocked monitor takes
// results with random stalls. A behavioral copy of the task table is updated
// on every accepted request and queues the results the block owes. Each
// accepted result is checked field by field against the oldest one. The run
// covers a directed opening, a tick run that piles up pending runs, and
// random well-formed traffic. Two long receiver hold-offs fill the block and
// push the stall back to the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
  import tst_pkg::*;
();

  localparam int NSLOT       = MAX_TASKS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_LEN    = 300;   // cycles of each long receiver hold-off
  localparam int DRAIN_LEN   = 60;    // quiet cycles after the last result
  localparam int RUN_TICKS   = 12;    // ticks in the directed tick run

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  tick_scheduler_task_table #(.MAX_TASKS(NSLOT)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // local copy of the task table and the results it still owes
  // ---------------------------------------------------------------------------
  logic        t_used   [NSLOT];
  logic [15:0] t_tag    [NSLOT];
  logic [15:0] t_delay  [NSLOT];
  logic [15:0] t_period [NSLOT];
  logic [7:0]  t_runs   [NSLOT];

  req_t req_backlog_q [$];
  rsp_t owed_rsp_q [$];

  // run statistics
  int func_count [4];
  int runs_owed;
  int full_adds;
  int range_dels;
  int results_checked;
  int fails;

  function automatic void clear_slot(int s);
    t_used[s]   = 1'b0;
    t_tag[s]    = '0;
    t_delay[s]  = '0;
    t_period[s] = '0;
    t_runs[s]   = '0;
  endfunction

  // apply one accepted request to the table copy, queue the results it causes
  task automatic table_apply(input req_t r);
    rsp_t res [$];
    rsp_t o;
    int   s;
    func_count[r.func]++;
    o = '0;
    case (r.func)
      FUNC_TICK: begin
        // age every occupied slot; due slots gain a run and reload
        for (s = 0; s < NSLOT; s++) begin
          if (t_used[s]) begin
            if (t_delay[s] == 16'd0) begin
              if (t_runs[s] != 8'hFF) t_runs[s]++;
              if (t_period[s] != 16'd0) t_delay[s] = t_period[s];
            end else begin
              t_delay[s]--;
            end
          end
        end
        res.push_back(o);
      end
      FUNC_ADD: begin
        s = 0;
        while (s < NSLOT && t_used[s]) s++;
        if (s == NSLOT) begin
          o.status = ST_FULL;
          full_adds++;
        end else begin
          t_used[s]   = 1'b1;
          t_tag[s]    = r.task_tag;
          t_delay[s]  = r.start_delay;
          t_period[s] = r.repeat_period;
          t_runs[s]   = '0;
          o.slot_out  = 6'(s);
        end
        res.push_back(o);
      end
      FUNC_DEL: begin
        o.slot_out = r.slot_sel;
        if (r.slot_sel >= NSLOT) begin
          o.status = ST_RANGE;
          range_dels++;
        end else begin
          o.status = t_used[r.slot_sel] ? ST_OK : ST_EMPTY;
          clear_slot(r.slot_sel);
        end
        res.push_back(o);
      end
      FUNC_DISP: begin
        // one run per pending slot in slot order; one-shot slots vanish
        for (s = 0; s < NSLOT && res.size() < RES_CAP; s++) begin
          if (t_runs[s] != 8'd0) begin
            o.slot_out  = 6'(s);
            o.run_valid = 1'b1;
            o.run_tag   = t_tag[s];
            res.push_back(o);
            runs_owed++;
            t_runs[s]--;
            if (t_period[s] == 16'd0) clear_slot(s);
          end
        end
        if (res.size() == 0) res.push_back(o);
      end
    endcase
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) owed_rsp_q.push_back(res[i]);
  endtask

  function automatic req_t make_req(func_t f, logic [15:0] tg, logic [15:0] dl,
                                    logic [15:0] pr, logic [5:0] sl);
    req_t r;
    r.func          = f;
    r.task_tag      = tg;
    r.start_delay   = dl;
    r.repeat_period = pr;
    r.slot_sel      = sl;
    return r;
  endfunction

  // idle length for both sides: mostly short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    else if (p < 94) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // shared pacing: accepted item count, a calm window and the long hold-offs
  // ---------------------------------------------------------------------------
  int   req_count = 0;
  logic calm;
  logic hold_on = 1'b0;
  int   hold_left = 0;
  int   holds_done = 0;

  // no idling on either side inside this window
  assign calm = (req_count >= 105) && (req_count < 125);

  // long receiver hold-off, counted here; the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      hold_on    <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_on   <= (hold_left > 1);
    end else if ((holds_done == 0 && req_count >= 40) ||
                 (holds_done == 1 && req_count >= 100)) begin
      hold_on    <= 1'b1;
      hold_left  <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers backlog items, updates the table copy on each acceptance
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
      for (int s = 0; s < NSLOT; s++) clear_slot(s);
    end else begin
      if (req_valid && !req_stall) begin
        table_apply(req);
        req_count <= req_count + 1;
      end
      // payload only moves once the current item is gone
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_backlog_q.size() != 0) begin
          req       <= req_backlog_q.pop_front();
          req_valid <= 1'b1;
          gap_left = (calm || $urandom_range(0, 99) < 50) ? 0 : idle_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random result stalls, checks every accepted result
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  rsp_t want_rsp;
  int   cycle_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("cycle %0d: result with none owed: status=%0d slot=%0d run=%0b tag=%h last=%0b",
                     cycle_count, rsp.status, rsp.slot_out, rsp.run_valid, rsp.run_tag,
                     rsp.last);
        end else begin
          want_rsp = owed_rsp_q.pop_front();
          results_checked++;
          if (rsp.status !== want_rsp.status || rsp.slot_out !== want_rsp.slot_out ||
              rsp.run_valid !== want_rsp.run_valid || rsp.run_tag !== want_rsp.run_tag ||
              rsp.last !== want_rsp.last) begin
            fails++;
            if (fails <= 10) begin
              $display("cycle %0d: result mismatch", cycle_count);
              $display("  want status=%0d slot=%0d run=%0b tag=%h last=%0b",
                       want_rsp.status, want_rsp.slot_out, want_rsp.run_valid,
                       want_rsp.run_tag, want_rsp.last);
              $display("  got  status=%0d slot=%0d run=%0b tag=%h last=%0b",
                       rsp.status, rsp.slot_out, rsp.run_valid, rsp.run_tag, rsp.last);
            end
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
      rsp_stall <= hold_on || (stall_left > 0);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_rsp_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int burst;
    int nrand;
    logic [15:0] dl;
    logic [15:0] pr;

    // directed opening: empty table cases, field extremes, a full table
    req_backlog_q.push_back(make_req(FUNC_DISP, '0, '0, '0, '0));   // nothing pending
    req_backlog_q.push_back(make_req(FUNC_TICK, '0, '0, '0, '0));   // tick on empty table
    req_backlog_q.push_back(make_req(FUNC_DEL, '0, '0, '0, 6'd0));  // slot already empty
    req_backlog_q.push_back(make_req(FUNC_DEL, '0, '0, '0, 6'd63)); // out of range, top
    req_backlog_q.push_back(make_req(FUNC_DEL, '0, '0, '0, 6'd8));  // first out of range
    // one-shot due at once, a task with period one, and the longest delay and period
    req_backlog_q.push_back(make_req(FUNC_ADD, 16'hFFFF, 16'd0, 16'd0, '0));
    req_backlog_q.push_back(make_req(FUNC_ADD, 16'h0000, 16'd0, 16'd1, '0));
    req_backlog_q.push_back(make_req(FUNC_ADD, 16'h1234, 16'hFFFF, 16'hFFFF, 6'h3F));
    for (int i = 0; i < NSLOT - 3; i++)
      req_backlog_q.push_back(make_req(FUNC_ADD, 16'hA000 + 16'(i), 16'd1, 16'd2, '0));
    req_backlog_q.push_back(make_req(FUNC_ADD, 16'hDEAD, 16'd5, 16'd5, '0)); // table full
    // two ticks give the one-shot two runs; dispatch drops the second
    req_backlog_q.push_back(make_req(FUNC_TICK, '0, '0, '0, '0));
    req_backlog_q.push_back(make_req(FUNC_TICK, '0, '0, '0, '0));
    req_backlog_q.push_back(make_req(FUNC_DISP, '0, '0, '0, '0));
    req_backlog_q.push_back(make_req(FUNC_DISP, '0, '0, '0, '0));
    req_backlog_q.push_back(make_req(FUNC_DEL, '0, '0, '0, 6'd2));
    req_backlog_q.push_back(make_req(FUNC_DEL, '0, '0, '0, 6'd7));

    // tick run: an undispatched one-shot keeps gaining runs, periodic slots pile up
    req_backlog_q.push_back(make_req(FUNC_ADD, 16'h5A5A, 16'd0, 16'd0, '0));
    for (int i = 0; i < RUN_TICKS; i++)
      req_backlog_q.push_back(make_req(FUNC_TICK, '0, '0, '0, '0));
    req_backlog_q.push_back(make_req(FUNC_DISP, '0, '0, '0, '0));
    for (int i = 0; i < NSLOT; i++)
      req_backlog_q.push_back(make_req(FUNC_DEL, '0, '0, '0, 6'(i)));

    // random traffic: short delays and periods so tasks come due often;
    // fields an operation ignores carry random noise
    nrand = 0;
    while (nrand < 108) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if ($urandom_range(0, 4) == 0) begin
          dl = 16'($urandom);
          pr = 16'($urandom);
        end else begin
          dl = 16'($urandom_range(0, 3));
          pr = 16'($urandom_range(0, 4));
        end
        req_backlog_q.push_back(make_req(FUNC_ADD, 16'($urandom), dl, pr, 6'($urandom)));
        nrand++;
      end else if (pick < 55) begin
        burst = $urandom_range(1, 5);
        for (int i = 0; i < burst; i++) begin
          req_backlog_q.push_back(make_req(FUNC_TICK, 16'($urandom), 16'($urandom),
                                           16'($urandom), 6'($urandom)));
          nrand++;
        end
      end else if (pick < 80) begin
        req_backlog_q.push_back(make_req(FUNC_DISP, 16'($urandom), 16'($urandom),
                                         16'($urandom), 6'($urandom)));
        nrand++;
      end else begin
        // mostly real slots, sometimes beyond the table
        req_backlog_q.push_back(make_req(FUNC_DEL, 16'($urandom), 16'($urandom),
                                         16'($urandom),
                                         ($urandom_range(0, 5) == 0) ?
                                         6'($urandom_range(8, 63)) :
                                         6'($urandom_range(0, NSLOT - 1))));
        nrand++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all items accepted and every owed result seen, then a quiet stretch
    while (req_backlog_q.size() != 0 || req_valid || owed_rsp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    $display("run covered %0d items: %0d tick, %0d add (%0d on a full table), %0d delete",
             req_count, func_count[FUNC_TICK], func_count[FUNC_ADD], full_adds,
             func_count[FUNC_DEL]);
    $display("  (%0d out of range), %0d dispatch; %0d results checked, %0d task runs, %0d bad",
             range_dels, func_count[FUNC_DISP], results_checked, runs_owed, fails);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
